// ----- hdl/iacf_pkg.sv -----
// Shared types and constants for the IMU calibrate and filter block.
package iacf_pkg;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_ACCUM  = 2'd1,
    ACT_CALIB  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_FILTER_EN = 2'd0,
    CFG_IS_ACCEL  = 2'd1,
    CFG_GRAVITY   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_FINISH,
    ST_OUT
  } state_e;

  localparam int unsigned NumAxes = 3;
  // moving-average length; a power of two so the mean is a shift
  localparam int unsigned Taps     = 4;
  localparam int unsigned TapShift = $clog2(Taps);
  localparam int unsigned DivBits = 56;
  localparam logic signed [47:0] Max48 = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] Min48 = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] Max32 = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] Min32 = {1'b1, {31{1'b0}}};

  typedef struct packed {
    logic       start;    // capture item, apply first-phase work
    logic       div_load; // load divider for current axis
    logic       div_step; // one quotient bit
    logic       store;    // write quotient result for current axis
    logic       finish;   // final per-item updates
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic need_div;  // item uses the divider
    logic div_last;  // divider on its final bit
  } status_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'(signed'(Max48))) return Max48;
    if (v < 50'(signed'(Min48))) return Min48;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'(signed'(Max32))) return Max32;
    if (v < 49'(signed'(Min32))) return Min32;
    return v[31:0];
  endfunction

endpackage

// ----- hdl/imu_axis_calibrate_filter.sv -----
// Top level of the IMU bias removal and moving-average block.
//
// Input channel (in_valid_i/in_ready_o) carries one action per transaction:
// update, accumulate, calibrate or clear. Output channel
// (out_valid_o/out_ready_i) returns one result transaction for every input.
// Config port: cfg_we_i, cfg_index_i, cfg_data_i; write only while idle.
//
// Each item steps through the axes in turn, deciding on a divide for each,
// then takes a finishing step before the result is offered. Clear and
// accumulate never divide; calibrate with a nonzero divisor, and update
// on each axis with a nonzero change and interval, run the shared 56-bit
// restoring divider for that axis, and the serial divider sets the rate.
// One item is worked at a time, so in_ready_o is low from acceptance until the
// result is taken.
//
// Reset clears all state to zero and the registers to their reset values.
// A stalled receiver holds the result steady; no new input is taken meanwhile.
// Tap history and the moving average lie in flip-flops, four entries per axis.
module imu_axis_calibrate_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] x_sample_i,
  input  logic signed [31:0] y_sample_i,
  input  logic signed [31:0] z_sample_i,
  input  logic [31:0]        interval_i,
  input  logic [15:0]        divisor_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_corrected_o,
  output logic signed [31:0] y_corrected_o,
  output logic signed [31:0] z_corrected_o,
  output logic signed [31:0] x_smoothed_o,
  output logic signed [31:0] y_smoothed_o,
  output logic signed [31:0] z_smoothed_o,
  output logic signed [47:0] x_running_sum_o,
  output logic signed [47:0] y_running_sum_o,
  output logic signed [47:0] z_running_sum_o,
  output logic signed [31:0] x_rate_o,
  output logic signed [31:0] y_rate_o,
  output logic signed [31:0] z_rate_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  logic        filt_en_q, is_accel_q;
  logic [23:0] gravity_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_en_q  <= 1'b1;
      is_accel_q <= 1'b0;
      gravity_q  <= 24'd642689;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        iacf_pkg::CFG_FILTER_EN: filt_en_q  <= cfg_data_i[0];
        iacf_pkg::CFG_IS_ACCEL:  is_accel_q <= cfg_data_i[0];
        iacf_pkg::CFG_GRAVITY:   gravity_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  iacf_pkg::cmd_t    cmd;
  iacf_pkg::status_t sts;

  iacf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  logic signed [31:0] corr [3];
  logic signed [31:0] smth [3];
  logic signed [47:0] rsum [3];
  logic signed [31:0] rate [3];

  iacf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .filter_en_i (filt_en_q),
    .is_accel_i  (is_accel_q),
    .gravity_i   (gravity_q),
    .action_i    (action_i),
    .x_sample_i  (x_sample_i),
    .y_sample_i  (y_sample_i),
    .z_sample_i  (z_sample_i),
    .interval_i  (interval_i),
    .divisor_i   (divisor_i),
    .corr_o      (corr),
    .smooth_o    (smth),
    .rsum_o      (rsum),
    .rate_o      (rate)
  );

  assign x_corrected_o   = corr[0];
  assign y_corrected_o   = corr[1];
  assign z_corrected_o   = corr[2];
  assign x_smoothed_o    = smth[0];
  assign y_smoothed_o    = smth[1];
  assign z_smoothed_o    = smth[2];
  assign x_running_sum_o = rsum[0];
  assign y_running_sum_o = rsum[1];
  assign z_running_sum_o = rsum[2];
  assign x_rate_o        = rate[0];
  assign y_rate_o        = rate[1];
  assign z_rate_o        = rate[2];

endmodule

// ----- hdl/iacf_ctrl.sv -----
// Sequencer for the IMU block: one transaction at a time, serial divide per axis.
module iacf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  iacf_pkg::status_t sts_i,
  output iacf_pkg::cmd_t    cmd_o
);

  iacf_pkg::state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iacf_pkg::ST_IDLE;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    cmd_o     = '0;
    cmd_o.axis = axis_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      iacf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          axis_d  = '0;
          state_d = iacf_pkg::ST_LOAD;
        end
      end
      iacf_pkg::ST_LOAD: begin
        // each axis decides on its own whether it needs the divider
        if (sts_i.need_div) begin
          cmd_o.div_load = 1'b1;
          state_d = iacf_pkg::ST_DIV;
        end else if (axis_q == 2'(iacf_pkg::NumAxes - 1)) begin
          state_d = iacf_pkg::ST_FINISH;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      iacf_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = iacf_pkg::ST_STORE;
      end
      iacf_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        if (axis_q == 2'(iacf_pkg::NumAxes - 1)) begin
          state_d = iacf_pkg::ST_FINISH;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = iacf_pkg::ST_LOAD;
        end
      end
      iacf_pkg::ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = iacf_pkg::ST_OUT;
      end
      iacf_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = iacf_pkg::ST_IDLE;
      end
      default: state_d = iacf_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/iacf_datapath.sv -----
// Datapath: offsets, tap history, running sums, rates and a shared serial divider.
module iacf_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iacf_pkg::cmd_t      cmd_i,
  output iacf_pkg::status_t   sts_o,
  input  logic                filter_en_i,
  input  logic                is_accel_i,
  input  logic [23:0]         gravity_i,
  input  logic [1:0]          action_i,
  input  logic signed [31:0]  x_sample_i,
  input  logic signed [31:0]  y_sample_i,
  input  logic signed [31:0]  z_sample_i,
  input  logic [31:0]         interval_i,
  input  logic [15:0]         divisor_i,
  output logic signed [31:0]  corr_o   [3],
  output logic signed [31:0]  smooth_o [3],
  output logic signed [47:0]  rsum_o   [3],
  output logic signed [31:0]  rate_o   [3]
);

  localparam int unsigned SlotW = (iacf_pkg::Taps > 1) ? $clog2(iacf_pkg::Taps) : 1;
  localparam int unsigned AccW  = 32 + $clog2(iacf_pkg::Taps + 1);
  localparam int unsigned DivW  = iacf_pkg::DivBits;
  localparam int unsigned CntW  = $clog2(DivW);

  logic [1:0]         act_q;
  logic signed [31:0] smp_q [3];
  logic [31:0]        ivl_q;
  logic [15:0]        dvs_q;

  logic signed [47:0] off_q   [3];
  logic signed [31:0] corr_q  [3];
  logic signed [31:0] smooth_q[3];
  logic signed [47:0] rsum_q  [3];
  logic signed [31:0] rate_q  [3];
  logic signed [31:0] tap_q   [iacf_pkg::Taps][3];
  logic [SlotW-1:0]   slot_q;
  logic signed [31:0] chosen_q[3];
  logic signed [32:0] diff_q  [3];

  // filter stage commits in the first cycle after capture (controller LOAD of axis 0)
  logic upd_commit_q;

  // serial divider: restoring, unsigned magnitudes
  logic [DivW-1:0]  dnum_q, quo_q;
  logic [31:0]      rem_q;
  logic [31:0]      dden_q;
  logic [CntW-1:0]  cnt_q;
  logic             neg_q;

  logic signed [31:0] samples [3];
  assign samples[0] = x_sample_i;
  assign samples[1] = y_sample_i;
  assign samples[2] = z_sample_i;

  logic is_upd, is_cal;
  assign is_upd = act_q == iacf_pkg::ACT_UPDATE;
  assign is_cal = act_q == iacf_pkg::ACT_CALIB;

  // first-phase update values per axis
  logic signed [31:0] corr_n   [3];
  logic signed [31:0] chosen_n [3];
  logic signed [31:0] smooth_n [3];
  logic signed [32:0] diff_n   [3];

  // current axis divider operands; axis 0 is loaded while its change commits
  logic signed [47:0] off_ax;
  logic signed [32:0] diff_ax;
  assign off_ax  = off_q[cmd_i.axis];
  assign diff_ax = upd_commit_q ? diff_n[cmd_i.axis] : diff_q[cmd_i.axis];

  assign sts_o.need_div = (is_cal && dvs_q != '0) ||
                          (is_upd && diff_ax != '0 && ivl_q != '0);
  assign sts_o.div_last = cnt_q == CntW'(DivW - 1);

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem_q, dnum_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dden_q};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [AccW-1:0] acc;
      corr_n[a] = iacf_pkg::sat32(49'(smp_q[a]) - 49'(off_q[a]));
      acc = AccW'(corr_n[a]);
      for (int t = 0; t < iacf_pkg::Taps; t++) begin
        if (SlotW'(t) != slot_q) acc = acc + AccW'(tap_q[t][a]);
      end
      // mean truncated toward zero: bias negatives before the shift
      if (acc[AccW-1]) acc = acc + AccW'(iacf_pkg::Taps - 1);
      smooth_n[a] = 32'(acc >>> iacf_pkg::TapShift);
      chosen_n[a] = filter_en_i ? smooth_n[a] : corr_n[a];
      diff_n[a] = 33'(chosen_n[a]) -
                  33'(filter_en_i ? smooth_q[a] : corr_q[a]);
    end
  end

  logic [DivW-1:0] quo_next;
  assign quo_next = {quo_q[DivW-2:0], ~rem_sub[32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        off_q[a]    <= '0;
        corr_q[a]   <= '0;
        smooth_q[a] <= '0;
        rsum_q[a]   <= '0;
        rate_q[a]   <= '0;
        smp_q[a]    <= '0;
        chosen_q[a] <= '0;
        diff_q[a]   <= '0;
        for (int t = 0; t < iacf_pkg::Taps; t++) tap_q[t][a] <= '0;
      end
      slot_q       <= '0;
      cnt_q        <= '0;
      act_q        <= '0;
      ivl_q        <= '0;
      dvs_q        <= '0;
      upd_commit_q <= 1'b0;
      dnum_q       <= '0;
      quo_q        <= '0;
      rem_q        <= '0;
      dden_q       <= '0;
      neg_q        <= 1'b0;
    end else begin
      upd_commit_q <= cmd_i.start;
      if (cmd_i.start) begin
        act_q <= action_i;
        for (int a = 0; a < 3; a++) smp_q[a] <= samples[a];
        ivl_q <= interval_i;
        dvs_q <= divisor_i;
        if (action_i == iacf_pkg::ACT_ACCUM) begin
          for (int a = 0; a < 3; a++)
            off_q[a] <= iacf_pkg::sat48(50'(off_q[a]) + 50'(samples[a]));
        end
        if (action_i == iacf_pkg::ACT_CLEAR) begin
          for (int a = 0; a < 3; a++) begin
            smooth_q[a] <= '0;
            rsum_q[a]   <= '0;
            rate_q[a]   <= '0;
            for (int t = 0; t < iacf_pkg::Taps; t++) tap_q[t][a] <= '0;
          end
        end
      end
      // update: registers captured last cycle, now commit filter stage
      if (upd_commit_q && is_upd) begin
        for (int a = 0; a < 3; a++) begin
          chosen_q[a] <= chosen_n[a];
          diff_q[a]   <= diff_n[a];
          corr_q[a]   <= corr_n[a];
          if (filter_en_i) begin
            tap_q[slot_q][a] <= corr_n[a];
            smooth_q[a]      <= smooth_n[a];
          end
        end
      end
      if (cmd_i.div_load) begin
        cnt_q <= '0;
        rem_q <= '0;
        quo_q <= '0;
        if (is_cal) begin
          neg_q  <= off_ax[47];
          dnum_q <= DivW'($unsigned(off_ax[47] ? -off_ax : off_ax));
          dden_q <= 32'(dvs_q);
        end else begin
          neg_q  <= diff_ax[32];
          dnum_q <= {DivW'(diff_ax[32] ? -diff_ax : diff_ax)} << 24;
          dden_q <= ivl_q;
        end
      end
      if (cmd_i.div_step) begin
        cnt_q  <= cnt_q + CntW'(1);
        dnum_q <= {dnum_q[DivW-2:0], 1'b0};
        rem_q  <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
        quo_q  <= quo_next;
      end
      if (cmd_i.store) begin
        if (is_cal) begin
          off_q[cmd_i.axis] <= neg_q ? -48'(quo_q) : 48'(quo_q);
        end else begin
          if (!neg_q)
            rate_q[cmd_i.axis] <= (quo_q > DivW'(iacf_pkg::Max32)) ?
                                  iacf_pkg::Max32 : quo_q[31:0];
          else
            rate_q[cmd_i.axis] <= (quo_q > DivW'(33'h080000000)) ?
                                  iacf_pkg::Min32 : -quo_q[31:0];
        end
      end
      if (cmd_i.finish) begin
        if (is_cal && is_accel_i)
          off_q[2] <= iacf_pkg::sat48(50'(off_q[2]) - 50'(gravity_i));
        if (is_upd) begin
          for (int a = 0; a < 3; a++) begin
            rsum_q[a] <= iacf_pkg::sat48(50'(rsum_q[a]) + 50'(chosen_q[a]));
            if (diff_q[a] == '0) rate_q[a] <= '0;
            else if (ivl_q == '0) rate_q[a] <= diff_q[a][32] ? iacf_pkg::Min32
                                                            : iacf_pkg::Max32;
          end
          slot_q <= (slot_q == SlotW'(iacf_pkg::Taps - 1)) ? '0 : slot_q + SlotW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      corr_o[a]   = corr_q[a];
      smooth_o[a] = filter_en_i ? smooth_q[a] : corr_q[a];
      rsum_o[a]   = rsum_q[a];
      rate_o[a]   = rate_q[a];
    end
  end

endmodule

// ----- hdl/iacf_checker.sv -----
// Port-level assertions for the IMU block, bound to the top level.
module iacf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] x_corrected_o
);

  // one item in flight: never ready while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready with result pending");

  // an accepted item is never answered in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o) else $error("result too soon");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(x_corrected_o)))
    else $error("result dropped while stalled");

  // after delivery the block is ready again
  a_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o) else $error("not ready after result");

endmodule

bind imu_axis_calibrate_filter iacf_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .x_corrected_o (x_corrected_o)
);
